// ----- design/msr_pkg.sv -----
// Package for the message receive session block: item, job and config types,
// result kind codes, phase encoding and payload size.
// No dependencies.
package msr_pkg;

    // Payload bytes collected per message (3 to 63)
    localparam int unsigned PAYLOAD_BYTES = 6;
    localparam int unsigned IDX_W         = 6;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 16;

    // Payload size at write position width plus one bit
    localparam logic [IDX_W:0] PAYLOAD_LEN = (IDX_W+1)'(PAYLOAD_BYTES);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_TYPE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_TYPE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS    = 2'd3;

    // Result kinds
    localparam logic [2:0] KIND_ACK     = 3'd0;
    localparam logic [2:0] KIND_BYTE    = 3'd1;
    localparam logic [2:0] KIND_DONE    = 3'd2;
    localparam logic [2:0] KIND_ERROR   = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT = 3'd4;

    // Session phase
    typedef enum logic [1:0] {
        PH_REQ_FIRST  = 2'd0,
        PH_REQ_SECOND = 2'd1,
        PH_MSG_FIRST  = 2'd2,
        PH_MSG_SECOND = 2'd3
    } phase_t;

    typedef struct packed {
        logic        command;
        logic [31:0] link_word;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       result_kind;
        logic [7:0]       ack_destination;
        logic [15:0]      ack_sequence;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] byte_index;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  node_address;
        logic [7:0]  request_type_code;
        logic [7:0]  message_type_code;
        logic [15:0] message_timeout_ms;
    } cfg_t;

    // One classified item: either a single result or a group of payload
    // bytes optionally followed by a completion.
    typedef struct packed {
        logic             is_bytes;
        logic [2:0]       kind;
        logic [7:0]       ack_destination;
        logic [15:0]      ack_sequence;
        logic [1:0]       nbytes;
        logic             done;
        logic [IDX_W-1:0] first_index;
        logic [7:0]       byte0;
        logic [7:0]       byte1;
        logic [7:0]       byte2;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- design/msr_front.sv -----
// Front end: accepts items, holds the session state and the configuration
// registers, and turns each item into at most one job for the queue.
// Depends on msr_pkg.
module msr_front import msr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  in_item_t              item,
    output logic                  job_push,
    output job_t                  job
);

    cfg_t        cfg_reg;
    phase_t      phase_reg, phase_next;
    logic [31:0] held_reg, held_next;
    logic [7:0]  requester_reg, requester_next;
    logic        pair_reg, pair_next;
    logic [7:0]  first_hold_reg, first_hold_next;
    logic [3:0]  second_high_reg, second_high_next;
    logic [IDX_W-1:0] wpos_reg, wpos_next;
    logic [15:0] elapsed_reg, elapsed_next;

    logic [31:0] w;
    logic [9:0]  sum_wide;
    logic        sum_ok;
    logic [11:0] body;
    logic [IDX_W:0] remaining;
    logic [1:0]  nb;
    logic [IDX_W:0] wpos_after;
    logic        emit;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.node_address       <= 8'd1;
            cfg_reg.request_type_code  <= 8'd1;
            cfg_reg.message_type_code  <= 8'd3;
            cfg_reg.message_timeout_ms <= 16'd1000;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_NODE_ADDRESS: cfg_reg.node_address      <= cfg_data[7:0];
                CFG_REQUEST_TYPE: cfg_reg.request_type_code <= cfg_data[7:0];
                CFG_MESSAGE_TYPE: cfg_reg.message_type_code <= cfg_data[7:0];
                CFG_TIMEOUT_MS:   cfg_reg.message_timeout_ms <= cfg_data;
                default: ;
            endcase
        end
    end

    // Session state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg       <= PH_REQ_FIRST;
            held_reg        <= '0;
            requester_reg   <= 8'd1;
            pair_reg        <= 1'b0;
            first_hold_reg  <= '0;
            second_high_reg <= '0;
            wpos_reg        <= '0;
            elapsed_reg     <= '0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            held_reg        <= held_next;
            requester_reg   <= requester_next;
            pair_reg        <= pair_next;
            first_hold_reg  <= first_hold_next;
            second_high_reg <= second_high_next;
            wpos_reg        <= wpos_next;
            elapsed_reg     <= elapsed_next;
        end
    end

    // Packet checks and payload arithmetic
    assign w = item.link_word;
    assign sum_wide = 10'(held_reg[7:0]) + 10'(held_reg[15:8]) + 10'(held_reg[23:16])
                    + 10'(held_reg[31:24]) + 10'(w[7:0]) + 10'(w[15:8])
                    + 10'(w[23:16]) + 10'(w[31:24]);
    assign sum_ok     = (sum_wide[7:0] == 8'd0);
    assign body       = w[19:8];
    assign remaining  = PAYLOAD_LEN - {1'b0, wpos_reg};
    assign nb         = (remaining >= (IDX_W+1)'(3)) ? 2'd3 : remaining[1:0];
    assign wpos_after = {1'b0, wpos_reg} + (IDX_W+1)'(nb);

    // Next state and job
    always_comb begin
        phase_next       = phase_reg;
        held_next        = held_reg;
        requester_next   = requester_reg;
        pair_next        = pair_reg;
        first_hold_next  = first_hold_reg;
        second_high_next = second_high_reg;
        wpos_next        = wpos_reg;
        elapsed_next     = elapsed_reg;
        emit             = 1'b0;
        job              = '0;

        if (item.command) begin
            // millisecond tick
            case (phase_reg)
                PH_REQ_FIRST:
                begin
                    emit     = 1'b1;
                    job.kind = KIND_TIMEOUT;
                end
                PH_MSG_FIRST, PH_MSG_SECOND:
                begin
                    if (elapsed_reg != 16'hffff) begin
                        elapsed_next = elapsed_reg + 16'd1;
                    end
                    if (elapsed_next >= cfg_reg.message_timeout_ms) begin
                        emit       = 1'b1;
                        job.kind   = KIND_TIMEOUT;
                        phase_next = PH_REQ_FIRST;
                    end
                end
                default: ;
            endcase
        end else begin
            case (phase_reg)
                PH_REQ_FIRST:
                begin
                    if (w[31:24] == cfg_reg.request_type_code) begin
                        held_next  = w;
                        phase_next = PH_REQ_SECOND;
                    end else begin
                        emit     = 1'b1;
                        job.kind = KIND_ERROR;
                    end
                end
                PH_REQ_SECOND:
                begin
                    if (sum_ok && w[31:24] == 8'd0) begin
                        requester_next      = held_reg[7:0];
                        emit                = 1'b1;
                        job.kind            = KIND_ACK;
                        job.ack_destination = held_reg[7:0];
                        job.ack_sequence    = held_reg[23:8] + 16'd1;
                        phase_next          = PH_MSG_FIRST;
                        elapsed_next        = '0;
                        pair_next           = 1'b0;
                        wpos_next           = '0;
                    end else begin
                        emit       = 1'b1;
                        job.kind   = KIND_ERROR;
                        phase_next = PH_REQ_FIRST;
                    end
                end
                PH_MSG_FIRST:
                begin
                    if (w[31:24] == cfg_reg.message_type_code) begin
                        held_next  = w;
                        phase_next = PH_MSG_SECOND;
                    end
                end
                PH_MSG_SECOND:
                begin
                    if (sum_ok && w[31:24] == cfg_reg.node_address
                        && held_reg[7:0] == requester_reg) begin
                        elapsed_next = '0;
                        phase_next   = PH_MSG_FIRST;
                        if (!pair_reg) begin
                            first_hold_next  = body[11:4];
                            second_high_next = body[3:0];
                            pair_next        = 1'b1;
                        end else begin
                            pair_next       = 1'b0;
                            job.is_bytes    = 1'b1;
                            job.kind        = KIND_BYTE;
                            job.nbytes      = nb;
                            job.first_index = wpos_reg;
                            job.byte0       = first_hold_reg;
                            job.byte1       = {second_high_reg, body[11:8]};
                            job.byte2       = body[7:0];
                            job.done        = (wpos_after == PAYLOAD_LEN);
                            wpos_next       = wpos_after[IDX_W-1:0];
                            emit            = (nb != 2'd0) || job.done;
                            if (job.done) begin
                                phase_next = PH_REQ_FIRST;
                            end
                        end
                    end else begin
                        emit       = 1'b1;
                        job.kind   = KIND_ERROR;
                        phase_next = PH_REQ_FIRST;
                    end
                end
                default: ;
            endcase
        end
    end

    assign job_push = accept && emit;

endmodule

// ----- design/msr_queue.sv -----
// Two-entry job queue between the front end and the result sequencer.
// Depends on msr_pkg.
module msr_queue import msr_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          head,
    output queue_status_t status
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    // Entry storage
    always_ff @(posedge clk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push || pop)
        else $error("job pushed into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("job popped from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

// ----- design/msr_back.sv -----
// Result sequencer: expands the head job into one to four results and
// holds each in the output register until taken.
// Depends on msr_pkg.
module msr_back import msr_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      head,
    input  logic      head_valid,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic [1:0] step_reg;
    logic       valid_reg;
    out_item_t  item_reg;

    logic       load;
    logic [2:0] total;
    logic       is_last;
    out_item_t  item_next;

    assign load    = head_valid && (!valid_reg || !out_stall);
    assign total   = head.is_bytes ? 3'(head.nbytes) + 3'(head.done) : 3'd1;
    assign is_last = (3'(step_reg) + 3'd1 == total);
    assign pop     = load && is_last;

    // Build the result for the current step
    always_comb begin
        item_next      = '0;
        item_next.last = is_last;
        if (!head.is_bytes) begin
            item_next.result_kind     = head.kind;
            item_next.ack_destination = head.ack_destination;
            item_next.ack_sequence    = head.ack_sequence;
        end else if (2'(step_reg) < head.nbytes) begin
            item_next.result_kind = KIND_BYTE;
            item_next.byte_index  = head.first_index + IDX_W'(step_reg);
            case (step_reg)
                2'd0:    item_next.data_byte = head.byte0;
                2'd1:    item_next.data_byte = head.byte1;
                default: item_next.data_byte = head.byte2;
            endcase
        end else begin
            item_next.result_kind = KIND_DONE;
        end
    end

    // Step counter and output register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                step_reg  <= is_last ? 2'd0 : step_reg + 2'd1;
                valid_reg <= 1'b1;
            end else if (!out_stall) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_stall |=> valid_reg && $stable(item_reg))
        else $error("stalled result changed");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> 3'(step_reg) < total)
        else $error("sequencer step beyond job length");
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> step_reg == 2'd0)
        else $error("sequencer step left over without a job");

endmodule

// ----- design/message_receive_session.sv -----
// Channel   Dir  Handshake           Payload
// in        in   in_valid/in_stall   in_item_t  (command, link_word)
// out       out  out_valid/out_stall out_item_t (kind, ack, byte, index, last)
// cfg       in   cfg_write           cfg_index, cfg_data (16 bits)
//
// The front end classifies an item in the cycle it is accepted; up to two jobs
// wait in the queue. A job yields one result per cycle through the output
// register while out_stall is low, so an item gives zero to four results
// (payload pair with completion: four). in_stall rises only when the queue is full.
// Reset is asynchronous, active low, and returns to the idle request phase.
// Top level of the message receive session. Depends on msr_pkg, msr_front,
// msr_queue and msr_back.
module message_receive_session import msr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item
);

    logic          accept;
    logic          job_push;
    job_t          job;
    job_t          head;
    logic          pop;
    queue_status_t qstat;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !qstat.full;

    msr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (in_item),
        .job_push  (job_push),
        .job       (job)
    );

    msr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job),
        .pop      (pop),
        .head     (head),
        .status   (qstat)
    );

    msr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!qstat.empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule
